/* hw/rtl/life_pkg.sv */
package life_pkg;

  // grid size
  localparam int GRID_ROWS = 64;
  localparam int GRID_COLS = 64;

  localparam int ROW_AW = $clog2(GRID_ROWS);
  localparam int COL_AW = $clog2(GRID_COLS);
  // generation sweep counter runs 0 .. GRID_ROWS + 1
  localparam int CNT_W  = $clog2(GRID_ROWS + 2);

  // port payload widths
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 8;

  // operation codes
  localparam logic [1:0] MODE_WRITE   = 2'd0;
  localparam logic [1:0] MODE_READ    = 2'd1;
  localparam logic [1:0] MODE_ADVANCE = 2'd2;

  // b3/s23 rule
  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  typedef logic [GRID_COLS-1:0] row_t;

  typedef struct packed {
    logic accept;     // latch the incoming item, clear the result
    logic adv_clear;  // reset sweep counter and row window
    logic cell_rd;    // read the addressed row
    logic cell_op;    // finish a single-cell read or write
    logic adv_step;   // one step of the generation sweep
    logic out_load;   // move the result into the output register
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       on_grid;
    logic       adv_last;
    logic       out_free;
  } sts_t;

  // next state of one row from the rows above, itself and below
  function automatic row_t life_row(row_t up, row_t mid, row_t dn);
    row_t       up_l, up_r, mid_l, mid_r, dn_l, dn_r, nxt;
    logic [3:0] n;
    up_l  = up << 1;
    up_r  = up >> 1;
    mid_l = mid << 1;
    mid_r = mid >> 1;
    dn_l  = dn << 1;
    dn_r  = dn >> 1;
    nxt   = '0;
    for (int j = 0; j < GRID_COLS; j++) begin
      n = 4'(up_l[j]) + 4'(up[j]) + 4'(up_r[j]) + 4'(mid_l[j]) + 4'(mid_r[j])
        + 4'(dn_l[j]) + 4'(dn[j]) + 4'(dn_r[j]);
      nxt[j] = (n == BIRTH_COUNT) || (mid[j] && (n == SURVIVE_COUNT));
    end
    return nxt;
  endfunction

endpackage

/* hw/rtl/life_ram.sv */
module life_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hw/rtl/life_ctrl.sv */
module life_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  life_pkg::sts_t    sts,
  output life_pkg::cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_DISPATCH = 3'd1;
  localparam logic [2:0] ST_CELL_OP  = 3'd2;
  localparam logic [2:0] ST_ADV      = 3'd3;
  localparam logic [2:0] ST_RESP     = 3'd4;

  logic [2:0] state_r, state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (sts.mode == life_pkg::MODE_ADVANCE) begin
          cmd.adv_clear = 1'b1;
          state_nxt     = ST_ADV;
        end else if (sts.on_grid &&
                     (sts.mode inside {life_pkg::MODE_WRITE, life_pkg::MODE_READ})) begin
          cmd.cell_rd = 1'b1;
          state_nxt   = ST_CELL_OP;
        end else begin
          state_nxt = ST_RESP;
        end
      end
      ST_CELL_OP: begin
        cmd.cell_op = 1'b1;
        state_nxt   = ST_RESP;
      end
      ST_ADV: begin
        cmd.adv_step = 1'b1;
        if (sts.adv_last) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hw/rtl/life_dp.sv */
module life_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [life_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic [1:0]                       in_tuser,
  input  logic                             out_tready,
  output logic                             out_tvalid,
  output logic [life_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                             out_tuser,
  input  life_pkg::cmd_t                   cmd,
  output life_pkg::sts_t                   sts
);

  // latched item
  logic [1:0]                  mode_r;
  logic [5:0]                  row_r;
  logic [5:0]                  col_r;
  logic                        bit_r;

  // result and output register
  logic                        res_cell_r;
  logic                        res_done_r;
  logic                        out_vld_r;
  logic                        out_cell_r;
  logic                        out_done_r;

  // generation sweep
  logic [life_pkg::CNT_W-1:0]  cnt_r;
  life_pkg::row_t              up_r;
  life_pkg::row_t              mid_r;

  // row store and per-row valid bits (unwritten rows read as dead)
  logic [life_pkg::GRID_ROWS-1:0] row_vld_r;
  logic                        rd_live_r;

  logic                        rd_en, wr_en;
  logic [life_pkg::ROW_AW-1:0] rd_addr, wr_addr;
  logic [life_pkg::ROW_AW-1:0] row_addr, cnt_addr, sweep_wr_addr;
  logic [life_pkg::COL_AW-1:0] col_addr;
  life_pkg::row_t              rd_data, row_now, cell_row, gen_row, wr_data;
  logic                        adv_rd, adv_wr, adv_shift, adv_last;

  assign row_addr      = life_pkg::ROW_AW'(row_r);
  assign col_addr      = life_pkg::COL_AW'(col_r);
  assign cnt_addr      = life_pkg::ROW_AW'(cnt_r);
  assign sweep_wr_addr = life_pkg::ROW_AW'(cnt_r - life_pkg::CNT_W'(2));

  assign adv_last  = (cnt_r == life_pkg::CNT_W'(life_pkg::GRID_ROWS + 1));
  assign adv_rd    = cmd.adv_step && (cnt_r < life_pkg::CNT_W'(life_pkg::GRID_ROWS));
  assign adv_shift = cmd.adv_step && (cnt_r >= life_pkg::CNT_W'(1));
  assign adv_wr    = cmd.adv_step && (cnt_r >= life_pkg::CNT_W'(2));

  // row last read, forced dead when never written or nothing read
  assign row_now = rd_live_r ? rd_data : '0;

  always_comb begin
    cell_row           = row_now;
    cell_row[col_addr] = bit_r;
  end

  assign gen_row = life_pkg::life_row(up_r, mid_r, row_now);

  assign rd_en   = cmd.cell_rd || adv_rd;
  assign rd_addr = cmd.cell_rd ? row_addr : cnt_addr;
  assign wr_en   = (cmd.cell_op && (mode_r == life_pkg::MODE_WRITE)) || adv_wr;
  assign wr_addr = cmd.cell_op ? row_addr : sweep_wr_addr;
  assign wr_data = cmd.cell_op ? cell_row : gen_row;

  life_ram #(
    .WIDTH (life_pkg::GRID_COLS),
    .DEPTH (life_pkg::GRID_ROWS)
  ) u_grid (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_live_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        row_vld_r[wr_addr] <= 1'b1;
      end
      rd_live_r <= rd_en && row_vld_r[rd_addr];
      if (cmd.out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r     <= in_tuser;
      row_r      <= in_tdata[5:0];
      col_r      <= in_tdata[11:6];
      bit_r      <= in_tdata[12];
      res_cell_r <= 1'b0;
      res_done_r <= 1'b0;
    end
    if (cmd.cell_op && (mode_r == life_pkg::MODE_READ)) begin
      res_cell_r <= row_now[col_addr];
    end
    if (cmd.adv_step && adv_last) begin
      res_done_r <= 1'b1;
    end
    if (cmd.adv_clear) begin
      cnt_r <= '0;
      up_r  <= '0;
      mid_r <= '0;
    end else if (cmd.adv_step) begin
      cnt_r <= cnt_r + life_pkg::CNT_W'(1);
      if (adv_shift) begin
        up_r  <= mid_r;
        mid_r <= row_now;
      end
    end
    if (cmd.out_load) begin
      out_cell_r <= res_cell_r;
      out_done_r <= res_done_r;
    end
  end

  assign sts.mode     = mode_r;
  assign sts.on_grid  = (32'(row_r) < life_pkg::GRID_ROWS) &&
                        (32'(col_r) < life_pkg::GRID_COLS);
  assign sts.adv_last = adv_last;
  assign sts.out_free = !out_vld_r || out_tready;

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {(life_pkg::OUT_DATA_W - 1)'(0), out_cell_r};
  assign out_tuser  = out_done_r;

endmodule

/* hw/rtl/life_cellular_automaton_step.sv */
// Game of life (b3/s23) on a 64 x 64 grid with dead borders, all cells dead
// after reset. Each input transfer carries one operation in in_tuser: write
// one cell, read one cell, or advance the grid a generation; every operation
// returns exactly one output transfer (cell value for a read, step_done flag
// in out_tuser for an advance, zeros otherwise). The grid lives in a
// row-wide memory with one valid flag per row, so reset needs no clearing
// pass. A cell read or write runs through dispatch, row read, update and
// result before the next transfer is accepted; an advance sweeps the grid,
// reading one row per cycle and writing each new row back in place once the
// row below it has been read, the old rows kept in a three-row window. The
// output register lets a new operation be taken while the previous result
// waits for the sink.
module life_cellular_automaton_step (
  input  logic                             clk,
  input  logic                             rst_n,
  // operation in
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [life_pkg::IN_DATA_W-1:0]   in_tdata,   // row[5:0], col[11:6], cell_in[12]
  input  logic [1:0]                       in_tuser,   // mode[1:0]
  // result out
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [life_pkg::OUT_DATA_W-1:0]  out_tdata,  // cell_out[0]
  output logic                             out_tuser   // step_done[0]
);

  life_pkg::cmd_t cmd;
  life_pkg::sts_t sts;

  // sequencer: one operation at a time
  life_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // grid store, generation sweep and output register
  life_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .sts        (sts)
  );

  // a result never overwrites one still waiting in the output register
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_tvalid || out_tready))
    else $error("result loaded over a pending transfer");

  // no new operation is taken while a sweep runs
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.adv_step |-> !in_tready)
    else $error("operation accepted during a generation sweep");

  // the sweep stops after its final row
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.adv_step && sts.adv_last) |=> !cmd.adv_step)
    else $error("generation sweep ran past the last row");

  // an accepted operation leads to its dispatch next cycle, not to another accept
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> !in_tready)
    else $error("second operation accepted before dispatch");

endmodule
